// ===== rtl/gop_pkg.sv =====
// shared types, register codes and angle constants of the gradient orientation quantizer
package gop_pkg;

    // configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [1:0] REG_DIRECTION_COUNT = 2'd2;

    // register widths and reset values
    localparam int DIM_W = 15;
    localparam int DIR_W = 7;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 15'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 15'd480;
    localparam logic [DIR_W-1:0] DIR_RESET    = 7'd60;

    // angle format: pi is 2^31
    localparam int CORDIC_STEPS = 31;
    localparam int VEC_W   = 64;
    localparam int ANGLE_W = 34;
    localparam int THETA_W = 32;
    localparam int FRAC_POS = 60;
    localparam logic [63:0] PI_Q29 = 64'd1686629713;
    localparam logic [THETA_W-1:0] HALF_TURN    = 32'h8000_0000;
    localparam logic [THETA_W-1:0] QUARTER_TURN = 32'h4000_0000;

    // vector state handed from one rotation stage to the next
    typedef struct packed {
        logic signed [VEC_W-1:0]   x;
        logic signed [VEC_W-1:0]   y;
        logic signed [ANGLE_W-1:0] z;
        logic                      base;
        logic                      fixed;
        logic [THETA_W-1:0]        fixed_theta;
        logic                      outside;
    } gop_vec_t;

    // floor(2^e / d) by restoring long division, used at elaboration only
    function automatic logic [63:0] pow2_div(input int e, input logic [63:0] d);
        logic [63:0] num;
        logic [63:0] rem;
        logic [63:0] quo;
        num = 64'd1 << e;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[62:0], num[b]};
            if (rem >= d)
            begin
                rem = rem - d;
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // rotation angle of step i: atan(2^-i) series in Q60, scaled so pi is 2^31
    function automatic logic [ANGLE_W-1:0] step_angle(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int odd;
        int e;
        sum = '0;
        if (i == 0)
        begin
            return ANGLE_W'(64'd1 << 29);
        end
        for (int n = 0; n < 31; n++)
        begin
            odd = 2 * n + 1;
            e = i * odd;
            if (e <= FRAC_POS)
            begin
                term = pow2_div(FRAC_POS - e, 64'(odd));
                if (n % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
            end
        end
        return ANGLE_W'((sum + PI_Q29 / 2) / PI_Q29);
    endfunction

endpackage

// ===== rtl/gop_cordic_stage.sv =====
// one vectoring rotation step of the angle pipeline
module gop_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  gop_pkg::gop_vec_t in_vec,
    output logic             out_valid,
    output gop_pkg::gop_vec_t out_vec
);

    localparam logic signed [gop_pkg::ANGLE_W-1:0] ANGLE = gop_pkg::step_angle(STEP);

    logic signed [gop_pkg::VEC_W-1:0] xs;
    logic signed [gop_pkg::VEC_W-1:0] ys;
    logic              valid_reg;
    gop_pkg::gop_vec_t vec_reg;
    gop_pkg::gop_vec_t vec_next;

    // rotate toward the x axis; a vector already on the axis is left alone
    always_comb
    begin
        xs = $signed(in_vec.x) >>> STEP;
        ys = $signed(in_vec.y) >>> STEP;
        vec_next = in_vec;
        if (!in_vec.y[gop_pkg::VEC_W-1] && (in_vec.y != '0))
        begin
            vec_next.x = in_vec.x + ys;
            vec_next.y = in_vec.y - xs;
            vec_next.z = in_vec.z + ANGLE;
        end
        else if (in_vec.y[gop_pkg::VEC_W-1])
        begin
            vec_next.x = in_vec.x - ys;
            vec_next.y = in_vec.y + xs;
            vec_next.z = in_vec.z - ANGLE;
        end
    end

    // stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (en)
            vec_reg <= vec_next;
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;

endmodule

// ===== rtl/gradient_orientation_quantizer_top.sv =====
// top level of the gradient orientation quantizer
// Takes one request per cycle while s_tready is high and returns one result per request, in order.
// The bounds check and quadrant fold are registered at the accepting edge, then come 31
// pipelined CORDIC vectoring stages (one rotation step each), then one register each for
// the angle clamp, the bin multiply and the final bin clamp.
// When the output is not taken the whole pipeline holds and s_tready drops.
// Configuration writes apply at once and should only be made while the pipeline is empty.
module gradient_orientation_quantizer_top #(
    parameter int GRAD_WIDTH     = 16,
    parameter int MAX_DIRECTIONS = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    // pos_x[15:0], pos_y[31:16], grad_x, grad_y (GRAD_WIDTH each), zero fill to bytes
    input  logic [((32 + 2 * GRAD_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    input  logic       s_tvalid,
    output logic       s_tready,
    // orientation_index[5:0], outside[6], zero [7]
    output logic [7:0] m_tdata,
    output logic       m_tvalid,
    input  logic       m_tready,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [gop_pkg::DIM_W-1:0] cfg_data
);

    localparam int SHIFT = gop_pkg::FRAC_POS - GRAD_WIDTH;
    localparam int NSTEP = gop_pkg::CORDIC_STEPS;
    localparam int DW    = gop_pkg::DIR_W;
    localparam int PROD_W = gop_pkg::THETA_W + DW;
    localparam int IDX_W  = PROD_W - 31;

    // configuration registers
    logic [gop_pkg::DIM_W-1:0] image_width_reg;
    logic [gop_pkg::DIM_W-1:0] image_height_reg;
    logic [DW-1:0]             direction_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg     <= gop_pkg::WIDTH_RESET;
            image_height_reg    <= gop_pkg::HEIGHT_RESET;
            direction_count_reg <= gop_pkg::DIR_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gop_pkg::REG_IMAGE_WIDTH:     image_width_reg  <= cfg_data;
                gop_pkg::REG_IMAGE_HEIGHT:    image_height_reg <= cfg_data;
                gop_pkg::REG_DIRECTION_COUNT: direction_count_reg <= cfg_data[DW-1:0];
                default: ;
            endcase
        end
    end

    // effective bin count: zero reads as one, saturated at the maximum
    logic [DW-1:0] n_eff;
    always_comb
    begin
        if (direction_count_reg == '0)
            n_eff = DW'(1);
        else if (32'(direction_count_reg) > MAX_DIRECTIONS)
            n_eff = DW'(MAX_DIRECTIONS);
        else
            n_eff = direction_count_reg;
    end

    // whole pipeline moves when the output register is free or being taken
    logic advance;
    logic out_valid_reg;
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    // input fields
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [GRAD_WIDTH-1:0] grad_x;
    logic signed [GRAD_WIDTH-1:0] grad_y;
    assign pos_x  = s_tdata[15:0];
    assign pos_y  = s_tdata[31:16];
    assign grad_x = s_tdata[32 +: GRAD_WIDTH];
    assign grad_y = s_tdata[32 + GRAD_WIDTH +: GRAD_WIDTH];

    // bounds check, fold into the upper half plane, special angles
    gop_pkg::gop_vec_t pre_next;
    logic signed [gop_pkg::VEC_W-1:0] gx;
    logic signed [gop_pkg::VEC_W-1:0] gy;
    logic signed [gop_pkg::VEC_W-1:0] u;
    logic signed [gop_pkg::VEC_W-1:0] v;
    always_comb
    begin
        gx = gop_pkg::VEC_W'(grad_x);
        gy = gop_pkg::VEC_W'(grad_y);
        if (gy[gop_pkg::VEC_W-1])
        begin
            u = -gx;
            v = -gy;
        end
        else
        begin
            u = gx;
            v = gy;
        end
        pre_next.outside = pos_x[15] || pos_y[15]
                           || (pos_x[14:0] >= image_width_reg)
                           || (pos_y[14:0] >= image_height_reg);
        pre_next.z    = '0;
        pre_next.base = 1'b0;
        pre_next.fixed = 1'b0;
        pre_next.fixed_theta = '0;
        pre_next.x = u <<< SHIFT;
        pre_next.y = v <<< SHIFT;
        priority if (v == '0)
        begin
            pre_next.fixed = 1'b1;
            pre_next.fixed_theta = u[gop_pkg::VEC_W-1] ? gop_pkg::HALF_TURN : '0;
            pre_next.x = '0;
            pre_next.y = '0;
        end
        else if (u == '0)
        begin
            pre_next.fixed = 1'b1;
            pre_next.fixed_theta = gop_pkg::QUARTER_TURN;
            pre_next.x = '0;
            pre_next.y = '0;
        end
        else if (u[gop_pkg::VEC_W-1])
        begin
            // second quadrant: turn by -pi/2 and add pi/2 back at the end
            pre_next.base = 1'b1;
            pre_next.x = v <<< SHIFT;
            pre_next.y = (-u) <<< SHIFT;
        end
        else
        begin
            pre_next.base = 1'b0;
        end
    end

    // chain of stage outputs: entry 0 is the fold stage
    logic [NSTEP:0]    chain_valid;
    gop_pkg::gop_vec_t chain_vec [0:NSTEP];
    logic              pre_valid_reg;
    gop_pkg::gop_vec_t pre_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pre_valid_reg <= 1'b0;
        else if (advance)
            pre_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            pre_reg <= pre_next;
    end

    assign chain_valid[0] = pre_valid_reg;
    assign chain_vec[0]   = pre_reg;

    // rotation stages
    for (genvar i = 0; i < NSTEP; i++)
    begin : g_step
        gop_cordic_stage #(.STEP(i)) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .in_valid  (chain_valid[i]),
            .in_vec    (chain_vec[i]),
            .out_valid (chain_valid[i+1]),
            .out_vec   (chain_vec[i+1])
        );
    end

    // angle: add quadrant base and clamp to [0, pi]
    gop_pkg::gop_vec_t last_vec;
    logic signed [gop_pkg::ANGLE_W-1:0] angle_sum;
    logic [gop_pkg::THETA_W-1:0] theta_next;
    logic [gop_pkg::THETA_W-1:0] theta_reg;
    logic theta_valid_reg;
    logic theta_outside_reg;
    assign last_vec  = chain_vec[NSTEP];
    assign angle_sum = last_vec.z + (last_vec.base
                       ? gop_pkg::ANGLE_W'(gop_pkg::QUARTER_TURN) : '0);
    always_comb
    begin
        priority if (last_vec.fixed)
            theta_next = last_vec.fixed_theta;
        else if (angle_sum[gop_pkg::ANGLE_W-1])
            theta_next = '0;
        else if (angle_sum > $signed(gop_pkg::ANGLE_W'(gop_pkg::HALF_TURN)))
            theta_next = gop_pkg::HALF_TURN;
        else
            theta_next = angle_sum[gop_pkg::THETA_W-1:0];
    end

    // bin multiply
    logic [PROD_W-1:0] prod_reg;
    logic prod_valid_reg;
    logic prod_outside_reg;

    // final clamp and output register
    logic [IDX_W-1:0] idx_raw;
    logic [IDX_W-1:0] idx_full;
    logic [IDX_W-1:0] idx_reg;
    logic outside_reg;
    assign idx_raw = prod_reg[PROD_W-1:31];
    always_comb
    begin
        if (prod_outside_reg)
            idx_full = '0;
        else if (idx_raw >= IDX_W'(n_eff))
            idx_full = IDX_W'(n_eff) - IDX_W'(1);
        else
            idx_full = idx_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            theta_valid_reg <= 1'b0;
            prod_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (advance)
        begin
            theta_valid_reg <= chain_valid[NSTEP];
            prod_valid_reg  <= theta_valid_reg;
            out_valid_reg   <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            theta_reg         <= theta_next;
            theta_outside_reg <= last_vec.outside;
            prod_reg          <= PROD_W'(theta_reg) * PROD_W'(n_eff);
            prod_outside_reg  <= theta_outside_reg;
            idx_reg           <= idx_full;
            outside_reg       <= prod_outside_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, outside_reg, idx_reg[5:0]};

    // an outside point always reports bin zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && outside_reg |-> idx_reg == '0)
        else $error("outside result with nonzero bin");

    // a delivered bin lies below the effective bin count
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !outside_reg |-> idx_reg < IDX_W'(n_eff))
        else $error("bin not below bin count");

    // clamped angle never exceeds pi
    assert property (@(posedge clk) disable iff (!rst_n)
        theta_valid_reg |-> theta_reg <= gop_pkg::HALF_TURN)
        else $error("angle beyond half turn");

    // a stall freezes every valid bit in the rotation chain
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(chain_valid))
        else $error("rotation chain moved during stall");

endmodule

// ===== dv/gradient_orientation_quantizer_top_test.sv =====
// testbench for the gradient orientation quantizer: directed table plus random requests
module gradient_orientation_quantizer_top_test;

    localparam int GRAD_W       = 16;
    localparam int MAX_DIRS     = 64;
    localparam int ROT_STEPS    = 31;
    localparam int PIPE_LATENCY = 35;
    localparam int IDLE_LIMIT   = 5000;
    localparam int HOLD_CYCLES  = 300;
    localparam int N_PROBES     = 24;
    localparam int N_PHASES     = 7;

    // one result: bin and outside flag
    typedef struct packed {
        logic       outside;
        logic [5:0] bin;
    } orient_t;

    // directed row: request fields, then the typed result where it is obvious
    typedef struct packed {
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] gx;
        logic [15:0] gy;
        logic        known;
        logic        outside;
        logic [5:0]  bin;
    } probe_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic [63:0] s_tdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  m_tdata;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = gop_pkg::REG_IMAGE_WIDTH;
    logic [gop_pkg::DIM_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [gop_pkg::DIM_W-1:0] width_model  = gop_pkg::WIDTH_RESET;
    logic [gop_pkg::DIM_W-1:0] height_model = gop_pkg::HEIGHT_RESET;
    logic [gop_pkg::DIR_W-1:0] dirs_model   = gop_pkg::DIR_RESET;

    longint  rot_angle [ROT_STEPS];
    orient_t orient_q [$];
    int      mismatch_count = 0;
    int      idle_cycles = 0;
    int      burst_left = 0;
    bit      hold_off_req = 1'b0;

    // reset config is 640 x 480 with 60 bins
    probe_t probe_tab [N_PROBES] = '{
        '{16'd0,    16'd0,    16'd0,    16'd0,    1'b1, 1'b0, 6'd0},
        '{16'd639,  16'd479,  16'd100,  16'd0,    1'b1, 1'b0, 6'd0},
        '{16'd10,   16'd10,   16'hFF9C, 16'd0,    1'b1, 1'b0, 6'd59},
        '{16'd10,   16'd10,   16'd0,    16'd100,  1'b1, 1'b0, 6'd30},
        '{16'd10,   16'd10,   16'd0,    16'hFF9C, 1'b1, 1'b0, 6'd30},
        '{16'd640,  16'd0,    16'd5,    16'd5,    1'b1, 1'b1, 6'd0},
        '{16'd0,    16'd480,  16'd5,    16'd5,    1'b1, 1'b1, 6'd0},
        '{16'hFFFF, 16'd0,    16'd5,    16'd5,    1'b1, 1'b1, 6'd0},
        '{16'd0,    16'hFFFF, 16'd5,    16'd5,    1'b1, 1'b1, 6'd0},
        '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b1, 1'b1, 6'd0},
        '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 1'b1, 1'b1, 6'd0},
        '{16'd1,    16'd1,    16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 6'd0},
        '{16'd1,    16'd1,    16'h8000, 16'h8000, 1'b0, 1'b0, 6'd0},
        '{16'd2,    16'd3,    16'h8000, 16'h7FFF, 1'b0, 1'b0, 6'd0},
        '{16'd5,    16'd5,    16'h7FFF, 16'h8000, 1'b0, 1'b0, 6'd0},
        '{16'd5,    16'd5,    16'h8000, 16'd0,    1'b1, 1'b0, 6'd59},
        '{16'd5,    16'd5,    16'h7FFF, 16'd0,    1'b1, 1'b0, 6'd0},
        '{16'd5,    16'd5,    16'd0,    16'h8000, 1'b1, 1'b0, 6'd30},
        '{16'd5,    16'd5,    16'd1,    16'd1,    1'b0, 1'b0, 6'd0},
        '{16'd5,    16'd5,    16'hFFFF, 16'd1,    1'b0, 1'b0, 6'd0},
        '{16'd5,    16'd5,    16'd1,    16'hFFFF, 1'b0, 1'b0, 6'd0},
        '{16'd5,    16'd5,    16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 6'd0},
        '{16'd320,  16'd240,  16'd1000, 16'hFFFF, 1'b0, 1'b0, 6'd0},
        '{16'd320,  16'd240,  16'hFC18, 16'hFFFF, 1'b0, 1'b0, 6'd0}
    };

    // register settings per phase, extremes included
    int phase_width  [N_PHASES] = '{32767, 1, 16384, 0,   640, 200,   1000};
    int phase_height [N_PHASES] = '{32767, 1, 100,   480, 0,   16384, 1000};
    int phase_dirs   [N_PHASES] = '{64,    1, 0,     127, 7,   65,    2};
    int phase_items  [N_PHASES] = '{120,   120, 120, 60,  60,  120,   120};

    gradient_orientation_quantizer_top #(
        .GRAD_WIDTH     (GRAD_W),
        .MAX_DIRECTIONS (MAX_DIRS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // rotation angle of step i: atan(2^-i) series in Q60, rescaled so pi is 2^31
    function automatic longint atan_step(input int i);
        longint unsigned acc;
        longint unsigned term;
        int odd;
        acc = 0;
        if (i == 0)
            return longint'(1) << 29;
        for (int n = 0; i * (2 * n + 1) <= 60; n++)
        begin
            odd = 2 * n + 1;
            term = (64'd1 << (60 - i * odd)) / odd;
            if (n % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        return longint'((acc + gop_pkg::PI_Q29 / 2) / gop_pkg::PI_Q29);
    endfunction

    // binary angle of the gradient folded into [0, pi], pi being 2^31
    function automatic longint gradient_theta(input longint gx, input longint gy);
        longint u;
        longint v;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint t;
        z = 0;
        if (gy < 0)
        begin
            u = -gx;
            v = -gy;
        end
        else
        begin
            u = gx;
            v = gy;
        end
        if (v == 0)
            return (u < 0) ? longint'(gop_pkg::HALF_TURN) : 0;
        if (u == 0)
            return longint'(gop_pkg::QUARTER_TURN);
        // second quadrant: turn back by a quarter and add it afterwards
        if (u < 0)
        begin
            t = u;
            u = v;
            v = -t;
            z = longint'(gop_pkg::QUARTER_TURN);
        end
        x = u <<< (60 - GRAD_W);
        y = v <<< (60 - GRAD_W);
        for (int i = 0; i < ROT_STEPS; i++)
        begin
            if (y == 0)
                break;
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + rot_angle[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - rot_angle[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > longint'(gop_pkg::HALF_TURN))
            z = longint'(gop_pkg::HALF_TURN);
        return z;
    endfunction

    // expected bin and outside flag for one request under the current registers
    function automatic orient_t predict_orientation(input logic [15:0] px, input logic [15:0] py,
                                                    input logic [15:0] gx, input logic [15:0] gy);
        orient_t r;
        int xi;
        int yi;
        longint n;
        longint theta;
        longint bin;
        r = '0;
        xi = int'($signed(px));
        yi = int'($signed(py));
        if (xi < 0 || xi >= int'(width_model) || yi < 0 || yi >= int'(height_model))
        begin
            r.outside = 1'b1;
            return r;
        end
        n = longint'(dirs_model);
        if (n < 1)
            n = 1;
        if (n > MAX_DIRS)
            n = MAX_DIRS;
        theta = gradient_theta(longint'($signed(gx)), longint'($signed(gy)));
        bin = (theta * n) >>> 31;
        if (bin >= n)
            bin = n - 1;
        r.bin = bin[5:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'h0001;
            default: return 16'hFFFF;
        endcase
    endfunction

    // mostly inside the image, some on its border, some anywhere
    function automatic logic [15:0] random_coord(input logic [gop_pkg::DIM_W-1:0] lim);
        int l;
        l = int'(lim);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5, 6:
                if (l > 0)
                    return 16'($urandom_range(0, l - 1));
                else
                    return 16'($urandom);
            7:
                case ($urandom_range(0, 3))
                    0: return 16'(l - 1);
                    1: return 16'(l);
                    2: return 16'hFFFF;
                    default: return 16'h0000;
                endcase
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_gradient(output logic [15:0] gx, output logic [15:0] gy);
        logic [15:0] a;
        a = 16'($urandom);
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                gx = 16'($urandom);
                gy = 16'($urandom);
            end
            // small vectors, coarse angles
            6:
            begin
                gx = 16'($urandom_range(0, 16)) - 16'd8;
                gy = 16'($urandom_range(0, 16)) - 16'd8;
            end
            // on an axis
            7:
            begin
                if ($urandom_range(0, 1) == 1)
                begin
                    gx = 16'd0;
                    gy = a;
                end
                else
                begin
                    gx = a;
                    gy = 16'd0;
                end
            end
            8:
            begin
                gx = pick_extreme();
                gy = pick_extreme();
            end
            // diagonals
            default:
            begin
                gx = ($urandom_range(0, 1) == 1) ? a : -a;
                gy = ($urandom_range(0, 1) == 1) ? a : -a;
            end
        endcase
    endtask

    // offer one request in bursts with random gaps, log its result once taken
    task automatic send_request(input logic [63:0] data, input orient_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 12);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tdata  <= data;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        orient_q = {orient_q, want};
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (orient_q.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= gop_pkg::DIM_W'(value);
        @(posedge clk);
        case (idx)
            gop_pkg::REG_IMAGE_WIDTH:     width_model = gop_pkg::DIM_W'(value);
            gop_pkg::REG_IMAGE_HEIGHT:    height_model = gop_pkg::DIM_W'(value);
            gop_pkg::REG_DIRECTION_COUNT: dirs_model = gop_pkg::DIR_W'(value);
            default: ;
        endcase
    endtask

    task automatic run_random(input int count);
        logic [15:0] px;
        logic [15:0] py;
        logic [15:0] gx;
        logic [15:0] gy;
        for (int k = 0; k < count; k++)
        begin
            px = random_coord(width_model);
            py = random_coord(height_model);
            random_gradient(gx, gy);
            send_request({gy, gx, py, px}, predict_orientation(px, py, gx, gy));
        end
    endtask

    // receiver: stretches of steady, random and patterned stalls, plus one long hold
    initial
    begin
        int mode;
        int stretch;
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                mode = $urandom_range(0, 3);
                stretch = $urandom_range(10, 80);
                for (int k = 0; k < stretch && !hold_off_req; k++)
                begin
                    case (mode)
                        0: m_tready <= 1'b1;
                        1: m_tready <= 1'($urandom_range(0, 1));
                        2: m_tready <= ($urandom_range(0, 9) != 0);
                        default: m_tready <= (k % 3 != 0);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    // result checker and watchdog
    always @(posedge clk)
    begin
        orient_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (orient_q.size() == 0)
                begin
                    $error("result with no request outstanding: tdata %h", m_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = orient_q.pop_front();
                    if (m_tdata[5:0] !== want.bin)
                    begin
                        $error("orientation_index: expected %0d, got %0d", want.bin, m_tdata[5:0]);
                        mismatch_count++;
                    end
                    if (m_tdata[6] !== want.outside)
                    begin
                        $error("outside: expected %0d, got %0d", want.outside, m_tdata[6]);
                        mismatch_count++;
                    end
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // main sequence
    initial
    begin
        orient_t want;
        probe_t  row;
        for (int i = 0; i < ROT_STEPS; i++)
            rot_angle[i] = atan_step(i);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows under the reset settings
        for (int i = 0; i < N_PROBES; i++)
        begin
            row = probe_tab[i];
            if (row.known)
            begin
                want.bin = row.bin;
                want.outside = row.outside;
            end
            else
                want = predict_orientation(row.px, row.py, row.gx, row.gy);
            send_request({row.gy, row.gx, row.py, row.px}, want);
        end
        run_random(200);

        // register phases, each written with the pipeline empty
        for (int p = 0; p < N_PHASES; p++)
        begin
            drain_results();
            write_reg(gop_pkg::REG_IMAGE_WIDTH, phase_width[p]);
            write_reg(gop_pkg::REG_IMAGE_HEIGHT, phase_height[p]);
            write_reg(gop_pkg::REG_DIRECTION_COUNT, phase_dirs[p]);
            cfg_we <= 1'b0;
            if (p == 0)
                hold_off_req = 1'b1;
            run_random(phase_items[p]);
        end

        drain_results();
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/gop_pkg.sv
rtl/gop_cordic_stage.sv
rtl/gradient_orientation_quantizer_top.sv
dv/gradient_orientation_quantizer_top_test.sv
